// ===== rtl/core/mpd_pkg.sv =====
// Package for the Morse pulse decoder: widths, codes, register defaults,
// shared structs and the Morse code lookup. No dependencies.
package mpd_pkg;

	localparam int TimeW      = 16;
	localparam int CharW      = 7;
	localparam int CntW       = 3;
	localparam int CfgIdxW    = 2;
	localparam int KeyW       = 5;
	localparam int MaxSymDef  = 5;

	localparam logic [TimeW-1:0] DotMinRst   = 16'd1875;
	localparam logic [TimeW-1:0] DashMinRst  = 16'd12500;
	localparam logic [TimeW-1:0] DashMaxRst  = 16'd25000;
	localparam logic [TimeW-1:0] GapTicksRst = 16'd62500;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_POLL    = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_DOT  = 2'd0,
		KIND_DASH = 2'd1,
		KIND_CHAR = 2'd2
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DOT_MIN   = 2'd0,
		REG_DASH_MIN  = 2'd1,
		REG_DASH_MAX  = 2'd2,
		REG_GAP_TICKS = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [TimeW-1:0] dot_min;
		logic [TimeW-1:0] dash_min;
		logic [TimeW-1:0] dash_max;
		logic [TimeW-1:0] gap_ticks;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		logic [CharW-1:0] chr;
	} result_t;

	// bit i = symbol i, 1 = dash; bits above count are zero
	function automatic logic [CharW-1:0] morse_lookup(
		input logic [CntW-1:0] count,
		input logic [KeyW-1:0] bits
	);
		logic [CharW-1:0] ch;
		ch = '0;
		case (count)
			3'd1: begin
				case (bits)
					5'd0:    ch = 7'h45; // E
					5'd1:    ch = 7'h54; // T
					default: ch = '0;
				endcase
			end
			3'd2: begin
				case (bits)
					5'd0:    ch = 7'h49; // I
					5'd1:    ch = 7'h4E; // N
					5'd2:    ch = 7'h41; // A
					5'd3:    ch = 7'h4D; // M
					default: ch = '0;
				endcase
			end
			3'd3: begin
				case (bits)
					5'd0:    ch = 7'h53; // S
					5'd1:    ch = 7'h44; // D
					5'd2:    ch = 7'h52; // R
					5'd3:    ch = 7'h47; // G
					5'd4:    ch = 7'h55; // U
					5'd5:    ch = 7'h4B; // K
					5'd6:    ch = 7'h57; // W
					5'd7:    ch = 7'h4F; // O
					default: ch = '0;
				endcase
			end
			3'd4: begin
				case (bits)
					5'd0:    ch = 7'h48; // H
					5'd1:    ch = 7'h42; // B
					5'd2:    ch = 7'h4C; // L
					5'd3:    ch = 7'h5A; // Z
					5'd4:    ch = 7'h46; // F
					5'd5:    ch = 7'h43; // C
					5'd6:    ch = 7'h50; // P
					5'd8:    ch = 7'h56; // V
					5'd9:    ch = 7'h58; // X
					5'd11:   ch = 7'h51; // Q
					5'd13:   ch = 7'h59; // Y
					5'd14:   ch = 7'h4A; // J
					default: ch = '0;
				endcase
			end
			3'd5: begin
				case (bits)
					5'd0:    ch = 7'h35;
					5'd1:    ch = 7'h36;
					5'd3:    ch = 7'h37;
					5'd7:    ch = 7'h38;
					5'd15:   ch = 7'h39;
					5'd16:   ch = 7'h34;
					5'd24:   ch = 7'h33;
					5'd28:   ch = 7'h32;
					5'd30:   ch = 7'h31;
					5'd31:   ch = 7'h30;
					default: ch = '0;
				endcase
			end
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/core/mpd_if.sv =====
// Valid/ready channel interfaces for key events and decoded words.
// Depends on mpd_pkg for field widths.
interface mpd_key_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   opcode;
	logic [mpd_pkg::TimeW-1:0]    timer_value;

	modport source (output valid, output opcode, output timer_value, input ready);
	modport sink   (input valid, input opcode, input timer_value, output ready);
endinterface

interface mpd_sym_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   result_kind;
	logic [mpd_pkg::CharW-1:0]    char_code;

	modport source (output valid, output result_kind, output char_code, input ready);
	modport sink   (input valid, input result_kind, input char_code, output ready);
endinterface

// ===== rtl/core/mpd_symbol_unit.sv =====
// Pulse classification, symbol buffer and decode state for one word per cycle.
// Depends on mpd_pkg.
module mpd_symbol_unit #(
	parameter int MAX_SYMBOLS = mpd_pkg::MaxSymDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mpd_pkg::cfg_t             cfg,
	input  logic                      fire,
	input  mpd_pkg::opcode_t          op,
	input  logic [mpd_pkg::TimeW-1:0] tval,
	output logic                      res_valid,
	output mpd_pkg::result_t          res
);

	logic [mpd_pkg::TimeW-1:0] press_q, release_q;
	logic [MAX_SYMBOLS-1:0]    sym_bits_q;
	logic [mpd_pkg::CntW-1:0]  sym_cnt_q;
	logic                      overlong_q, decoded_q;

	logic [mpd_pkg::TimeW-1:0] width, since;
	logic                      is_dot, is_dash, gap_ok, room;
	logic [mpd_pkg::KeyW-1:0]  key_bits;
	logic [mpd_pkg::CharW-1:0] chr;

	for (genvar i = 0; i < mpd_pkg::KeyW; i++) begin : g_key
		if (i < MAX_SYMBOLS) begin : g_bit
			assign key_bits[i] = sym_bits_q[i];
		end else begin : g_zero
			assign key_bits[i] = 1'b0;
		end
	end

	always_comb begin
		width   = tval - press_q;
		since   = tval - release_q;
		is_dot  = (width >= cfg.dot_min) && (width < cfg.dash_min);
		is_dash = !is_dot && (width >= cfg.dash_min) && (width < cfg.dash_max);
		gap_ok  = (since >= cfg.gap_ticks) && !decoded_q;
		room    = sym_cnt_q < mpd_pkg::CntW'(MAX_SYMBOLS);
		chr     = overlong_q ? '0 : mpd_pkg::morse_lookup(sym_cnt_q, key_bits);

		res_valid = 1'b0;
		res.kind  = mpd_pkg::KIND_DOT;
		res.chr   = '0;
		case (op)
			mpd_pkg::OP_RELEASE: begin
				res_valid = is_dot || is_dash;
				res.kind  = is_dash ? mpd_pkg::KIND_DASH : mpd_pkg::KIND_DOT;
			end
			mpd_pkg::OP_POLL: begin
				res_valid = gap_ok && (chr != '0);
				res.kind  = mpd_pkg::KIND_CHAR;
				res.chr   = chr;
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q    <= '0;
			release_q  <= '0;
			sym_bits_q <= '0;
			sym_cnt_q  <= '0;
			overlong_q <= 1'b0;
			decoded_q  <= 1'b0;
		end else if (fire) begin
			case (op)
				mpd_pkg::OP_PRESS: press_q <= tval;
				mpd_pkg::OP_RELEASE: begin
					release_q <= tval;
					decoded_q <= 1'b0;
					if (is_dot || is_dash) begin
						if (room) begin
							if (is_dash)
								sym_bits_q <= sym_bits_q | (MAX_SYMBOLS'(1) << sym_cnt_q);
							sym_cnt_q <= sym_cnt_q + 1'b1;
						end else begin
							overlong_q <= 1'b1;
						end
					end
				end
				mpd_pkg::OP_POLL: begin
					if (gap_ok) begin
						decoded_q  <= 1'b1;
						sym_bits_q <= '0;
						sym_cnt_q  <= '0;
						overlong_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/morse_pulse_decoder.sv =====
// Morse pulse decoder top level: config registers, input and output registers.
// Depends on mpd_pkg, mpd_if and mpd_symbol_unit.
//
//  channel   dir  words                        payload
//  keys      in   press / release / poll       opcode, timer_value
//  symbols   out  dot, dash, decoded char      result_kind, char_code
//  cfg_*     in   register write               cfg_we, cfg_idx, cfg_data
//
// One word per cycle while the result is taken; a word enters the input
// register, is processed from there once the output register is free, and its
// result (if any) is registered in the output register.
// Reset clears the symbol buffer, times and flags; registers take defaults.
// A stalled result holds the output register; input stalls only when both
// registers are full and the result is not taken.
module morse_pulse_decoder #(
	parameter int MAX_SYMBOLS = mpd_pkg::MaxSymDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mpd_key_if.sink                     keys,
	mpd_sym_if.source                   symbols,
	input  logic                        cfg_we,
	input  logic [mpd_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [mpd_pkg::TimeW-1:0]   cfg_data
);

	mpd_pkg::cfg_t             cfg_q;
	logic                      valid_s1;
	mpd_pkg::opcode_t          op_s1;
	logic [mpd_pkg::TimeW-1:0] tval_s1;
	logic                      out_valid_q;
	mpd_pkg::result_t          out_q;
	logic                      take, out_free, fire, res_valid;
	mpd_pkg::result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_min   <= mpd_pkg::DotMinRst;
			cfg_q.dash_min  <= mpd_pkg::DashMinRst;
			cfg_q.dash_max  <= mpd_pkg::DashMaxRst;
			cfg_q.gap_ticks <= mpd_pkg::GapTicksRst;
		end else if (cfg_we) begin
			case (mpd_pkg::cfg_idx_t'(cfg_idx))
				mpd_pkg::REG_DOT_MIN:   cfg_q.dot_min   <= cfg_data;
				mpd_pkg::REG_DASH_MIN:  cfg_q.dash_min  <= cfg_data;
				mpd_pkg::REG_DASH_MAX:  cfg_q.dash_max  <= cfg_data;
				mpd_pkg::REG_GAP_TICKS: cfg_q.gap_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free   = !out_valid_q || symbols.ready;
	assign fire       = valid_s1 && out_free;
	assign keys.ready = !valid_s1 || out_free;
	assign take       = keys.valid && keys.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= mpd_pkg::opcode_t'(keys.opcode);
			tval_s1 <= keys.timer_value;
		end
	end

	mpd_symbol_unit #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_symbol (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.op        (op_s1),
		.tval      (tval_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= res_valid;
		else if (symbols.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid)
			out_q <= res;
	end

	assign symbols.valid       = out_valid_q;
	assign symbols.result_kind = out_q.kind;
	assign symbols.char_code   = out_q.chr;

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == mpd_pkg::KIND_CHAR) |-> (out_q.chr != '0))
		else $error("decoded char word with zero code");

	a_symbol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != mpd_pkg::KIND_CHAR) |-> (out_q.chr == '0))
		else $error("dot or dash word with nonzero code");

	a_symbol_from_release: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid && res.kind != mpd_pkg::KIND_CHAR)
			|-> (op_s1 == mpd_pkg::OP_RELEASE))
		else $error("symbol produced by a non-release word");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!keys.ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free register");

endmodule
